### rtl/core/mrgb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrgb_pkg
// Shared types, constants and helpers for the masked RGB to RGBA8 converter.
// ----------------------------------------------------------------------------
package mrgb_pkg;

    // register map, index = paddr / 4
    localparam int REG_NUM        = 6;
    localparam int REG_IDX_W      = 3;
    localparam int PADDR_W        = REG_IDX_W + 2;
    localparam logic [REG_IDX_W-1:0] REG_BPP         = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RED_MASK    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GREEN_MASK  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BLUE_MASK   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_MASK  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_EN    = 3'd5;

    localparam logic [2:0]  BPP_RST         = 3'd4;
    localparam logic [31:0] RED_MASK_RST    = 32'h00FF_0000;
    localparam logic [31:0] GREEN_MASK_RST  = 32'h0000_FF00;
    localparam logic [31:0] BLUE_MASK_RST   = 32'h0000_00FF;
    localparam logic [31:0] ALPHA_MASK_RST  = 32'hFF00_0000;
    localparam logic        ALPHA_EN_RST    = 1'b1;

    // channel codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_ALPHA = 2'd3;

    // divider: dividend is v*255 (32 + 8 bits), divisor 2^n-1 with n < 8
    localparam int DIV_DW    = 40;
    localparam int DIV_RW    = 7;
    localparam int DIV_BITS  = 4;
    localparam int DIV_ITERS = DIV_DW / DIV_BITS;
    localparam int ITER_W    = 4;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_LOAD,
        ST_PREP,
        ST_DIV,
        ST_STORE,
        ST_DELIVER
    } mrgb_state_t;

    typedef struct packed {
        logic [2:0]  bpp;
        logic [31:0] red_mask;
        logic [31:0] green_mask;
        logic [31:0] blue_mask;
        logic [31:0] alpha_mask;
        logic        alpha_en;
    } mrgb_cfg_t;

    typedef struct packed {
        logic       take_byte;
        logic       load_chan;
        logic       prep;
        logic       div_step;
        logic       store_chan;
        logic       load_out;
        logic [1:0] chan;
    } mrgb_cmd_t;

    typedef struct packed {
        logic pix_last;
        logic out_free;
    } mrgb_stat_t;

    function automatic logic [4:0] mrgb_tz(input logic [31:0] m);
        logic [4:0] n;
        n = '0;
        for (int i = 31; i >= 0; i--) begin
            if (m[i]) n = 5'(i);
        end
        return n;
    endfunction

    function automatic logic [5:0] mrgb_ones(input logic [31:0] m);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 32; i++) begin
            n = n + {5'd0, m[i]};
        end
        return n;
    endfunction

endpackage
`default_nettype wire

### rtl/core/mrgb_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrgb_div
// Restoring divider, DIV_BITS quotient bits per step; keeps low 8 quotient bits.
// ----------------------------------------------------------------------------
module mrgb_div
    import mrgb_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              start,
    input  wire logic              step,
    input  wire logic [DIV_DW-1:0] dividend,
    input  wire logic [DIV_RW-1:0] divisor,
    output logic      [7:0]        quot
);

    logic [DIV_DW-1:0] num_reg, num_next;
    logic [DIV_RW-1:0] rem_reg, rem_next;
    logic [7:0]        quot_reg, quot_next;

    always_comb begin
        logic [DIV_RW:0] t;
        num_next  = num_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        t         = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            t        = {rem_next, num_next[DIV_DW-1]};
            num_next = {num_next[DIV_DW-2:0], 1'b0};
            if (t >= {1'b0, divisor}) begin
                t         = t - {1'b0, divisor};
                quot_next = {quot_next[6:0], 1'b1};
            end else begin
                quot_next = {quot_next[6:0], 1'b0};
            end
            rem_next = t[DIV_RW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= dividend;
            rem_reg  <= '0;
            quot_reg <= '0;
        end else if (step) begin
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule
`default_nettype wire

### rtl/core/mrgb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrgb_ctrl
// Sequencer: byte gathering, per-channel load/prep/divide/store, delivery.
// ----------------------------------------------------------------------------
module mrgb_ctrl
    import mrgb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire mrgb_stat_t stat,
    output mrgb_cmd_t       cmd
);

    mrgb_state_t       state_reg, state_next;
    logic [1:0]        chan_reg, chan_next;
    logic [ITER_W-1:0] iter_reg, iter_next;

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DIV_ITERS - 1);

    // next state and counters
    always_comb begin
        state_next = state_reg;
        chan_next  = chan_reg;
        iter_next  = iter_reg;
        unique case (state_reg)
            ST_FILL: begin
                if (s_valid && stat.pix_last) begin
                    state_next = ST_LOAD;
                    chan_next  = CH_RED;
                end
            end
            ST_LOAD: state_next = ST_PREP;
            ST_PREP: begin
                state_next = ST_DIV;
                iter_next  = '0;
            end
            ST_DIV: begin
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_LAST) state_next = ST_STORE;
            end
            ST_STORE: begin
                if (chan_reg == CH_ALPHA) begin
                    state_next = ST_DELIVER;
                end else begin
                    chan_next  = chan_reg + 2'd1;
                    state_next = ST_LOAD;
                end
            end
            ST_DELIVER: begin
                if (stat.out_free) state_next = ST_FILL;
            end
            default: state_next = ST_FILL;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        cmd.chan = chan_reg;
        s_ready  = 1'b0;
        unique case (state_reg)
            ST_FILL: begin
                s_ready       = 1'b1;
                cmd.take_byte = s_valid;
            end
            ST_LOAD:    cmd.load_chan  = 1'b1;
            ST_PREP:    cmd.prep       = 1'b1;
            ST_DIV:     cmd.div_step   = 1'b1;
            ST_STORE:   cmd.store_chan = 1'b1;
            ST_DELIVER: cmd.load_out   = stat.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
            chan_reg  <= CH_RED;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            iter_reg  <= iter_next;
        end
    end

endmodule
`default_nettype wire

### rtl/core/mrgb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrgb_datapath
// Pixel assembly, mask extract, 8-bit scaling and the output register.
// ----------------------------------------------------------------------------
module mrgb_datapath
    import mrgb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire mrgb_cfg_t  cfg,
    input  wire mrgb_cmd_t  cmd,
    output mrgb_stat_t      stat,
    input  wire logic [7:0] s_data_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_red,
    output logic [7:0]      m_green,
    output logic [7:0]      m_blue,
    output logic [7:0]      m_alpha
);

    // byte gathering
    logic [1:0]  pos_reg;
    logic [23:0] partial_reg;
    logic [31:0] pixel_reg;
    logic [1:0]  size_m1;
    logic [31:0] assembled;

    always_comb begin
        if (cfg.bpp < 3'd2)      size_m1 = 2'd1;
        else if (cfg.bpp > 3'd4) size_m1 = 2'd3;
        else                     size_m1 = 2'(cfg.bpp - 3'd1);
    end

    assign assembled     = {8'd0, partial_reg} | ({24'd0, s_data_byte} << {pos_reg, 3'b000});
    assign stat.pix_last = (pos_reg >= size_m1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            partial_reg <= '0;
        end else if (cmd.take_byte) begin
            if (stat.pix_last) begin
                pos_reg     <= '0;
                partial_reg <= '0;
            end else begin
                pos_reg     <= pos_reg + 2'd1;
                partial_reg <= assembled[23:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_byte && stat.pix_last) pixel_reg <= assembled;
    end

    // channel extract
    logic [31:0] mask_sel;
    logic        force_opaque;

    always_comb begin
        case (cmd.chan)
            CH_RED:   mask_sel = cfg.red_mask;
            CH_GREEN: mask_sel = cfg.green_mask;
            CH_BLUE:  mask_sel = cfg.blue_mask;
            default:  mask_sel = cfg.alpha_mask;
        endcase
    end

    assign force_opaque = (cmd.chan == CH_ALPHA) &&
                          (!cfg.alpha_en || (cfg.alpha_mask == '0));

    logic [31:0] val_reg;
    logic [5:0]  ones_reg;
    logic [7:0]  direct_reg;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_RW-1:0] divisor;
    logic [7:0]  quot;
    logic [7:0]  direct_next;
    logic [31:0] shifted;

    always_ff @(posedge aclk) begin
        if (cmd.load_chan) begin
            val_reg  <= (pixel_reg & mask_sel) >> mrgb_tz(mask_sel);
            ones_reg <= mrgb_ones(mask_sel);
        end
    end

    // v*255 = (v << 8) - v
    assign dividend = {val_reg, 8'd0} - {8'd0, val_reg};
    // 2^n - 1, only used while n < 8
    assign divisor  = DIV_RW'((8'd1 << ones_reg[2:0]) - 8'd1);
    assign shifted  = val_reg >> (ones_reg - 6'd8);
    assign direct_next = shifted[7:0];

    always_ff @(posedge aclk) begin
        if (cmd.prep) direct_reg <= direct_next;
    end

    mrgb_div u_div (
        .aclk     (aclk),
        .start    (cmd.prep),
        .step     (cmd.div_step),
        .dividend (dividend),
        .divisor  (divisor),
        .quot     (quot)
    );

    // per-channel result
    logic [7:0] res_reg [4];
    logic [7:0] chan_res;

    always_comb begin
        if (force_opaque)            chan_res = 8'hFF;
        else if (ones_reg == 6'd0)   chan_res = 8'd0;
        else if (ones_reg >= 6'd8)   chan_res = direct_reg;
        else                         chan_res = quot;
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_chan) res_reg[cmd.chan] <= chan_res;
    end

    // output register
    logic       m_valid_reg;
    logic [7:0] red_reg, green_reg, blue_reg, alpha_reg;

    assign stat.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            red_reg   <= res_reg[CH_RED];
            green_reg <= res_reg[CH_GREEN];
            blue_reg  <= res_reg[CH_BLUE];
            alpha_reg <= res_reg[CH_ALPHA];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_red   = red_reg;
    assign m_green = green_reg;
    assign m_blue  = blue_reg;
    assign m_alpha = alpha_reg;

endmodule
`default_nettype wire

### rtl/core/masked_rgb_pixel_to_rgba8.sv
`default_nettype none
// ----------------------------------------------------------------------------
// masked_rgb_pixel_to_rgba8
// Converts bit-mask RGB(A) pixel bytes into 8-bit RGBA transactions.
// ----------------------------------------------------------------------------
// Raw pixel bytes enter on the s_ channel, least significant byte first, and
// are gathered into little-endian pixels of bytes_per_pixel bytes (values
// below 2 act as 2, above 4 as 4). Every completed pixel yields one m_
// transaction with red, green, blue and alpha, each masked, right-aligned by
// the mask's trailing-zero count and scaled to 8 bits by the mask's set-bit
// count. Timing: bytes that do not end a pixel are taken at one per cycle. The
// byte that ends a pixel drops s_ready low while each of the four channels
// passes through extract, prepare, 10 steps of the shared 4-bit-per-cycle
// divider and store; a delivery state then hands the
// result to the output register. The output register lets the next pixel's
// bytes come in while a result still waits on m_ready; conversion of the
// following pixel stalls only if that result has still not been taken.
// Registers sit at byte address 4*index on the APB port: 0 bytes_per_pixel,
// 1 red_mask, 2 green_mask, 3 blue_mask, 4 alpha_mask, 5 alpha_enable.
// Write them only while the block is idle; a write does not clear a pixel
// that is partly gathered.
// ----------------------------------------------------------------------------
module masked_rgb_pixel_to_rgba8
    import mrgb_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    // configuration (APB)
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,

    // pixel bytes in
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_data_byte,

    // RGBA8 out
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [7:0]         m_red,
    output logic      [7:0]         m_green,
    output logic      [7:0]         m_blue,
    output logic      [7:0]         m_alpha
);

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    mrgb_cfg_t             cfg_reg;
    logic                  wr_en;
    logic [REG_IDX_W-1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    // write lands on the access phase
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bpp        <= BPP_RST;
            cfg_reg.red_mask   <= RED_MASK_RST;
            cfg_reg.green_mask <= GREEN_MASK_RST;
            cfg_reg.blue_mask  <= BLUE_MASK_RST;
            cfg_reg.alpha_mask <= ALPHA_MASK_RST;
            cfg_reg.alpha_en   <= ALPHA_EN_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BPP:        cfg_reg.bpp        <= pwdata[2:0];
                REG_RED_MASK:   cfg_reg.red_mask   <= pwdata;
                REG_GREEN_MASK: cfg_reg.green_mask <= pwdata;
                REG_BLUE_MASK:  cfg_reg.blue_mask  <= pwdata;
                REG_ALPHA_MASK: cfg_reg.alpha_mask <= pwdata;
                REG_ALPHA_EN:   cfg_reg.alpha_en   <= pwdata[0];
                default: ;  // unmapped, dropped
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_BPP:        prdata = {29'd0, cfg_reg.bpp};
            REG_RED_MASK:   prdata = cfg_reg.red_mask;
            REG_GREEN_MASK: prdata = cfg_reg.green_mask;
            REG_BLUE_MASK:  prdata = cfg_reg.blue_mask;
            REG_ALPHA_MASK: prdata = cfg_reg.alpha_mask;
            REG_ALPHA_EN:   prdata = {31'd0, cfg_reg.alpha_en};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath
    // ------------------------------------------------------------------
    mrgb_cmd_t  cmd;
    mrgb_stat_t stat;

    mrgb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mrgb_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .stat        (stat),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue),
        .m_alpha     (m_alpha)
    );

endmodule
`default_nettype wire
